// ===== rtl/core/pps_pkg.sv =====
// shared types and constants for the preemptive priority scheduler
// no dependencies; used by pps_cell and preemptive_priority_scheduler

package pps_pkg;

   localparam int MAX_JOBS_DEF = 16;

   localparam int TAG_W  = 8;
   localparam int PRIO_W = 8;
   localparam int TIME_W = 16;
   localparam int SUM_W  = 32;
   localparam int DONE_W = 5;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // one job as written into a slot
   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
      logic [TIME_W-1:0] release_at;
      logic [TIME_W-1:0] length;
   } pps_job_type;

   // token that walks the cell row during a tick and carries the best job so far
   typedef struct packed {
      logic              valid;
      logic              found;
      logic [TIME_W-1:0] now;
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
      logic [TIME_W-1:0] release_at;
      logic [TIME_W-1:0] length;
      logic [TIME_W-1:0] remaining;
   } pps_token_type;

endpackage

// ===== rtl/core/preemptive_priority_scheduler.sv =====
// Preemptive priority scheduler. A load beat (req_op = 0) stores one job in the next free
// slot if any; its response strobes the cycle after acceptance; a new load can be taken
// every cycle. A tick beat (req_op = 1) sends a scan token down a row of MAX_JOBS slot
// cells, one cell per cycle, which admits released jobs and picks the highest-priority
// ready one; once the token leaves the row, the ST_SCAN, ST_WAIT and ST_SUM states apply
// the run and update the waiting total; busy stays high until the tick response strobes.
// The response is shown for exactly one cycle on rsp_strobe and cannot be held off.
// depends on pps_pkg and pps_cell

module preemptive_priority_scheduler #(
   parameter int MAX_JOBS = pps_pkg::MAX_JOBS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_op,
   input  logic [pps_pkg::TAG_W-1:0]    req_job_tag,
   input  logic [pps_pkg::PRIO_W-1:0]   req_job_priority,
   input  logic [pps_pkg::TIME_W-1:0]   req_release_at,
   input  logic [pps_pkg::TIME_W-1:0]   req_run_length,
   output logic                         rsp_strobe,
   output logic                         rsp_accepted,
   output logic                         rsp_busy_res,
   output logic [pps_pkg::TAG_W-1:0]    rsp_ran_tag,
   output logic [pps_pkg::TIME_W-1:0]   rsp_left_after,
   output logic                         rsp_completed,
   output logic [pps_pkg::TIME_W-1:0]   rsp_job_wait,
   output logic [pps_pkg::SUM_W-1:0]    rsp_wait_sum,
   output logic [pps_pkg::DONE_W-1:0]   rsp_done_count,
   output logic [pps_pkg::TIME_W-1:0]   rsp_now_time
);

   localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W = $clog2(MAX_JOBS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_JOBS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_SUM
   } state_type;

   state_type                       state_ff;
   logic [CNT_W-1:0]                slot_count_ff;
   logic [pps_pkg::TIME_W-1:0]      clock_time_ff;
   logic [pps_pkg::SUM_W-1:0]       total_ff;
   logic [pps_pkg::DONE_W-1:0]      done_ff;
   logic                            inj_ff;
   logic                            found_ff;
   logic [pps_pkg::TAG_W-1:0]       tag_ff;
   logic [pps_pkg::TIME_W-1:0]      left_ff;
   logic [pps_pkg::TIME_W:0]        spent_ff;
   logic                            completed_ff;
   logic [pps_pkg::TIME_W-1:0]      wait_ff;

   logic                            rsp_strobe_ff;
   logic                            rsp_accepted_ff;
   logic                            rsp_busy_res_ff;
   logic [pps_pkg::TAG_W-1:0]       rsp_ran_tag_ff;
   logic [pps_pkg::TIME_W-1:0]      rsp_left_after_ff;
   logic                            rsp_completed_ff;
   logic [pps_pkg::TIME_W-1:0]      rsp_job_wait_ff;

   logic                            accept;
   logic                            has_room;
   logic                            ld_en;
   pps_pkg::pps_job_type            ld_job;
   logic                            dec_en;
   logic [IDX_W-1:0]                dec_idx;
   pps_pkg::pps_token_type          tok_chain [MAX_JOBS+1];
   logic [IDX_W-1:0]                idx_chain [MAX_JOBS+1];
   pps_pkg::pps_token_type          tok_exit;
   logic [pps_pkg::TIME_W:0]        spent_in;
   logic [pps_pkg::TIME_W:0]        now_ext;
   logic [pps_pkg::TIME_W-1:0]      wait_in;
   logic                            completed_in;
   logic [pps_pkg::SUM_W:0]         sum_in;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign has_room = (slot_count_ff < CNT_MAX);
   assign ld_en    = accept && (req_op == pps_pkg::OP_LOAD) && has_room;

   always_comb begin
      ld_job.tag        = req_job_tag;
      ld_job.prio       = req_job_priority;
      ld_job.release_at = req_release_at;
      // zero length is stored as one unit
      ld_job.length     = (req_run_length == '0) ? pps_pkg::TIME_W'(1) : req_run_length;
   end

   always_comb begin
      tok_chain[0]       = '0;
      tok_chain[0].valid = inj_ff;
      tok_chain[0].now   = clock_time_ff;
      idx_chain[0]       = '0;
   end

   for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
      pps_cell #(
         .IDX_W      (IDX_W),
         .CELL_INDEX (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ld_en   (ld_en),
         .ld_idx  (slot_count_ff[IDX_W-1:0]),
         .ld_job  (ld_job),
         .dec_en  (dec_en),
         .dec_idx (dec_idx),
         .tok_in  (tok_chain[g]),
         .idx_in  (idx_chain[g]),
         .tok_out (tok_chain[g+1]),
         .idx_out (idx_chain[g+1])
      );
   end

   assign tok_exit = tok_chain[MAX_JOBS];
   assign dec_en   = (state_ff == ST_SCAN) && tok_exit.valid && tok_exit.found;
   assign dec_idx  = idx_chain[MAX_JOBS];

   assign spent_in     = {1'b0, tok_exit.release_at} + {1'b0, tok_exit.length};
   assign now_ext      = {1'b0, clock_time_ff};
   assign completed_in = found_ff && (left_ff == '0);
   assign wait_in      = (completed_in && (now_ext > spent_ff))
                         ? pps_pkg::TIME_W'(now_ext - spent_ff) : '0;
   assign sum_in       = {1'b0, total_ff} + {{(pps_pkg::SUM_W - pps_pkg::TIME_W + 1){1'b0}},
                                             wait_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_count_ff <= '0;
         clock_time_ff <= '0;
         total_ff      <= '0;
         done_ff       <= '0;
         inj_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         inj_ff        <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_op == pps_pkg::OP_LOAD) begin
                     rsp_strobe_ff     <= 1'b1;
                     rsp_accepted_ff   <= has_room;
                     rsp_busy_res_ff   <= 1'b0;
                     rsp_ran_tag_ff    <= '0;
                     rsp_left_after_ff <= '0;
                     rsp_completed_ff  <= 1'b0;
                     rsp_job_wait_ff   <= '0;
                     if (has_room) begin
                        slot_count_ff <= slot_count_ff + 1'b1;
                     end
                  end else begin
                     inj_ff   <= 1'b1;
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (tok_exit.valid) begin
                  found_ff <= tok_exit.found;
                  tag_ff   <= tok_exit.found ? tok_exit.tag : '0;
                  left_ff  <= tok_exit.found ? (tok_exit.remaining - 1'b1) : '0;
                  spent_ff <= spent_in;
                  if (clock_time_ff != '1) begin
                     clock_time_ff <= clock_time_ff + 1'b1;
                  end
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               completed_ff <= completed_in;
               wait_ff      <= wait_in;
               state_ff     <= ST_SUM;
            end
            ST_SUM: begin
               total_ff <= sum_in[pps_pkg::SUM_W] ? '1 : sum_in[pps_pkg::SUM_W-1:0];
               if (completed_ff) begin
                  done_ff <= done_ff + 1'b1;
               end
               rsp_strobe_ff     <= 1'b1;
               rsp_accepted_ff   <= 1'b0;
               rsp_busy_res_ff   <= found_ff;
               rsp_ran_tag_ff    <= tag_ff;
               rsp_left_after_ff <= left_ff;
               rsp_completed_ff  <= completed_ff;
               rsp_job_wait_ff   <= wait_ff;
               state_ff          <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_accepted   = rsp_accepted_ff;
   assign rsp_busy_res   = rsp_busy_res_ff;
   assign rsp_ran_tag    = rsp_ran_tag_ff;
   assign rsp_left_after = rsp_left_after_ff;
   assign rsp_completed  = rsp_completed_ff;
   assign rsp_job_wait   = rsp_job_wait_ff;
   assign rsp_wait_sum   = total_ff;
   assign rsp_done_count = done_ff;
   assign rsp_now_time   = clock_time_ff;

   // the scan token leaves the row only while a tick is being scanned
   a_exit_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok_exit.valid |-> (state_ff == ST_SCAN))
      else $error("scan token left the cell row outside a tick");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      slot_count_ff <= CNT_MAX)
      else $error("slot count beyond table depth");

   // finished-job count moves only with a completing beat
   a_done_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_completed_ff) |-> $stable(done_ff))
      else $error("done count changed without a completion");

   a_sum_strobes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |=> (rsp_strobe_ff && (state_ff == ST_IDLE)))
      else $error("tick finished without a response beat");

endmodule

// ===== rtl/core/pps_cell.sv =====
// one job slot of the scheduler row: holds the job and passes the scan token on
// depends on pps_pkg

module pps_cell #(
   parameter int IDX_W      = 4,
   parameter int CELL_INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  ld_en,
   input  logic [IDX_W-1:0]      ld_idx,
   input  pps_pkg::pps_job_type  ld_job,
   input  logic                  dec_en,
   input  logic [IDX_W-1:0]      dec_idx,
   input  pps_pkg::pps_token_type tok_in,
   input  logic [IDX_W-1:0]      idx_in,
   output pps_pkg::pps_token_type tok_out,
   output logic [IDX_W-1:0]      idx_out
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   logic                          occ_ff;
   logic                          adm_ff;
   logic [pps_pkg::TAG_W-1:0]     tag_ff;
   logic [pps_pkg::PRIO_W-1:0]    prio_ff;
   logic [pps_pkg::TIME_W-1:0]    rel_ff;
   logic [pps_pkg::TIME_W-1:0]    len_ff;
   logic [pps_pkg::TIME_W-1:0]    rem_ff;
   pps_pkg::pps_token_type        tok_ff;
   pps_pkg::pps_token_type        tok_in_w;
   logic [IDX_W-1:0]              idx_ff;
   logic [IDX_W-1:0]              idx_in_w;

   logic release_due;
   logic ready;
   logic take;

   assign release_due = (rel_ff <= tok_in.now);
   assign ready       = occ_ff && (adm_ff || release_due) && (rem_ff != '0);
   assign take        = tok_in.valid && ready && (!tok_in.found || (prio_ff > tok_in.prio));

   always_comb begin
      tok_in_w = tok_in;
      idx_in_w = idx_in;
      if (take) begin
         tok_in_w.found      = 1'b1;
         tok_in_w.tag        = tag_ff;
         tok_in_w.prio       = prio_ff;
         tok_in_w.release_at = rel_ff;
         tok_in_w.length     = len_ff;
         tok_in_w.remaining  = rem_ff;
         idx_in_w            = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= 1'b0;
         adm_ff       <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_w;
         idx_ff <= idx_in_w;
         if (ld_en && (ld_idx == MY_IDX)) begin
            occ_ff  <= 1'b1;
            adm_ff  <= 1'b0;
            tag_ff  <= ld_job.tag;
            prio_ff <= ld_job.prio;
            rel_ff  <= ld_job.release_at;
            len_ff  <= ld_job.length;
            rem_ff  <= ld_job.length;
         end else begin
            // admission happens as the token passes, against the pre-tick time
            if (tok_in.valid && occ_ff && release_due) begin
               adm_ff <= 1'b1;
            end
            if (dec_en && (dec_idx == MY_IDX)) begin
               rem_ff <= rem_ff - 1'b1;
            end
         end
      end
   end

   assign tok_out = tok_ff;
   assign idx_out = idx_ff;

endmodule
